FILE: rtl/virtual_time_task_scheduler_assert.svh
// Assertion macros used by the scheduler's top-level RTL file.
`ifndef VIRTUAL_TIME_TASK_SCHEDULER_ASSERT_SVH
`define VIRTUAL_TIME_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define VTTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define VTTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vtts_pkg.sv
// Package with types, codes and constants of the virtual time task scheduler.
package vtts_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KIND_W    = 2;
  localparam int WEIGHT_W  = 16;
  localparam int SLOT_W    = 4;
  localparam int ID_W      = 32;
  localparam int VT_W      = 32;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W   = M_TDATA_W - SLOT_W - 1 - ID_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_START  = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef struct packed {
    logic latch;
    logic decode;
    logic find;
    logic create;
    logic start;
    logic charge_rd;
    logic charge_wr;
    logic scan;
    logic sub;
    logic scan_end;
    logic tick_end;
    logic id_take;
    logic res_zero;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              has_cur;
    logic              hit;
    logic              last;
    logic              start_ok;
    logic              sweep_done;
    logic              found;
    logic              out_free;
  } sts_t;

endpackage

FILE: rtl/vtts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module vtts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/vtts_ctrl.sv
// Controller state machine that sequences create, start and tick transactions.
module vtts_ctrl import vtts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_DECODE    = 12'b0000_0000_0010,
    ST_FIND      = 12'b0000_0000_0100,
    ST_CREATE    = 12'b0000_0000_1000,
    ST_START     = 12'b0000_0001_0000,
    ST_CHARGE_RD = 12'b0000_0010_0000,
    ST_CHARGE_WR = 12'b0000_0100_0000,
    ST_SCAN      = 12'b0000_1000_0000,
    ST_SUB       = 12'b0001_0000_0000,
    ST_TICK_END  = 12'b0010_0000_0000,
    ST_ID_WAIT   = 12'b0100_0000_0000,
    ST_RESULT    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        unique case (sts_i.kind)
          KIND_CREATE: state_d = ST_FIND;
          KIND_START:  state_d = ST_START;
          KIND_TICK:   state_d = sts_i.has_cur ? ST_CHARGE_RD : ST_SCAN;
          default: begin
            cmd_o.res_zero = 1'b1;
            state_d        = ST_RESULT;
          end
        endcase
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_CREATE;
        end else if (sts_i.last) begin
          cmd_o.res_zero = 1'b1;
          state_d        = ST_RESULT;
        end
      end
      ST_CREATE: begin
        cmd_o.create = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = sts_i.start_ok ? ST_ID_WAIT : ST_RESULT;
      end
      ST_CHARGE_RD: begin
        cmd_o.charge_rd = 1'b1;
        state_d         = ST_CHARGE_WR;
      end
      ST_CHARGE_WR: begin
        cmd_o.charge_wr = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.sweep_done) begin
          cmd_o.scan_end = 1'b1;
          state_d        = sts_i.found ? ST_SUB : ST_TICK_END;
        end
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_TICK_END;
        end
      end
      ST_TICK_END: begin
        cmd_o.tick_end = 1'b1;
        state_d        = sts_i.has_cur ? ST_ID_WAIT : ST_RESULT;
      end
      ST_ID_WAIT: begin
        cmd_o.id_take = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/vtts_dp.sv
// Datapath with the slot flags, the slot memories, the sweep counter and the result register.
module vtts_dp import vtts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [KIND_W-1:0]    s_axis_tuser_i,
  input  logic                 m_axis_tready_i,
  output logic                 m_axis_tvalid_o,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  logic [SLOTS-1:0]    alloc_q;
  logic [SLOTS-1:0]    run_q;
  logic [ID_W-1:0]     next_id_q;
  logic [IW-1:0]       cur_q;
  logic                has_cur_q;
  logic [IW-1:0]       idx_q;
  logic                done_q;
  logic                rd_vld_q;
  logic [IW-1:0]       rd_idx_q;
  logic                found_q;
  logic [VT_W-1:0]     min_q;
  logic [IW-1:0]       best_q;
  logic [KIND_W-1:0]   kind_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic                res_ok_q;
  logic [ID_W-1:0]     res_id_q;
  logic                m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  logic [CW-1:0]       slot_wide;
  logic                slot_in_range;
  logic [IW-1:0]       slot_idx;
  logic                start_ok;
  logic                issue;
  logic                better;
  logic [VT_W:0]       charge_sum;
  logic [VT_W-1:0]     charge_sat;

  logic                vt_we, vt_re;
  logic [IW-1:0]       vt_waddr, vt_raddr;
  logic [VT_W-1:0]     vt_wdata, vt_rdata;
  logic [WEIGHT_W-1:0] wt_rdata;
  logic                id_re;
  logic [IW-1:0]       id_raddr;
  logic [ID_W-1:0]     id_rdata;

  assign slot_wide     = CW'(slot_q);
  assign slot_in_range = {1'b0, slot_wide} < (CW + 1)'(SLOTS);
  assign slot_idx      = slot_wide[IW-1:0];
  assign start_ok      = slot_in_range && alloc_q[slot_idx];

  assign issue  = (cmd_i.scan || cmd_i.sub) && !done_q;
  assign better = run_q[rd_idx_q] && (!found_q || (vt_rdata < min_q));

  assign charge_sum = {1'b0, vt_rdata} + (VT_W + 1)'(wt_rdata);
  assign charge_sat = charge_sum[VT_W] ? '1 : charge_sum[VT_W-1:0];

  assign vt_re    = cmd_i.charge_rd || issue;
  assign vt_raddr = cmd_i.charge_rd ? cur_q : idx_q;

  always_comb begin
    vt_we    = 1'b0;
    vt_waddr = idx_q;
    vt_wdata = '0;
    if (cmd_i.create) begin
      vt_we = 1'b1;
    end else if (cmd_i.charge_wr) begin
      vt_we    = 1'b1;
      vt_waddr = cur_q;
      vt_wdata = charge_sat;
    end else if (cmd_i.sub && rd_vld_q && run_q[rd_idx_q]) begin
      vt_we    = 1'b1;
      vt_waddr = rd_idx_q;
      vt_wdata = vt_rdata - min_q;
    end
  end

  assign id_re    = (cmd_i.start && start_ok) || (cmd_i.tick_end && has_cur_q);
  assign id_raddr = cmd_i.start ? slot_idx : cur_q;

  vtts_ram #(.WIDTH(VT_W), .DEPTH(SLOTS)) u_vt_ram (
    .clk_i   (clk_i),
    .we_i    (vt_we),
    .waddr_i (vt_waddr),
    .wdata_i (vt_wdata),
    .re_i    (vt_re),
    .raddr_i (vt_raddr),
    .rdata_o (vt_rdata)
  );

  vtts_ram #(.WIDTH(WEIGHT_W), .DEPTH(SLOTS)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.create),
    .waddr_i (idx_q),
    .wdata_i (weight_q),
    .re_i    (cmd_i.charge_rd),
    .raddr_i (cur_q),
    .rdata_o (wt_rdata)
  );

  vtts_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.create),
    .waddr_i (idx_q),
    .wdata_i (next_id_q),
    .re_i    (id_re),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q   <= '0;
      run_q     <= '0;
      next_id_q <= '0;
      cur_q     <= '0;
      has_cur_q <= 1'b0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decode || cmd_i.scan_end) begin
        idx_q    <= '0;
        done_q   <= 1'b0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.find && alloc_q[idx_q] && (idx_q != LastIdx)) begin
        idx_q <= idx_q + IW'(1);
      end else if (cmd_i.scan || cmd_i.sub) begin
        rd_vld_q <= !done_q;
        if (!done_q) begin
          if (idx_q == LastIdx) begin
            done_q <= 1'b1;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
      end
      if (cmd_i.decode) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan && rd_vld_q && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.create) begin
        alloc_q[idx_q] <= 1'b1;
        next_id_q      <= next_id_q + ID_W'(1);
      end
      if (cmd_i.start && start_ok) begin
        run_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.scan_end && found_q) begin
        cur_q     <= best_q;
        has_cur_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q   <= s_axis_tuser_i;
      weight_q <= s_axis_tdata_i[WEIGHT_W-1:0];
      slot_q   <= s_axis_tdata_i[WEIGHT_W +: SLOT_W];
    end
    if (issue) begin
      rd_idx_q <= idx_q;
    end
    if (cmd_i.scan && rd_vld_q && better) begin
      min_q  <= vt_rdata;
      best_q <= rd_idx_q;
    end
    if (cmd_i.res_zero || (cmd_i.tick_end && !has_cur_q)) begin
      res_slot_q <= '0;
      res_ok_q   <= 1'b0;
      res_id_q   <= '0;
    end else if (cmd_i.create) begin
      res_slot_q <= SLOT_W'(idx_q);
      res_ok_q   <= 1'b1;
      res_id_q   <= next_id_q;
    end else if (cmd_i.start) begin
      res_slot_q <= slot_q;
      res_ok_q   <= start_ok;
      res_id_q   <= '0;
    end else if (cmd_i.tick_end) begin
      res_slot_q <= SLOT_W'(cur_q);
      res_ok_q   <= 1'b1;
    end else if (cmd_i.id_take) begin
      res_id_q <= id_rdata;
    end
    if (cmd_i.out_load) begin
      m_data_q <= {M_PAD_W'(0), res_id_q, res_ok_q, res_slot_q};
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.has_cur    = has_cur_q;
  assign sts_o.hit        = !alloc_q[idx_q];
  assign sts_o.last       = idx_q == LastIdx;
  assign sts_o.start_ok   = start_ok;
  assign sts_o.sweep_done = done_q && !rd_vld_q;
  assign sts_o.found      = found_q;
  assign sts_o.out_free   = !m_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

FILE: rtl/virtual_time_task_scheduler.sv
// Top level of the virtual time task scheduler: one result transaction per input transaction.
// A start checks the slot and, when it is allocated, reads the task id; kind 3 gives a zero result;
// a create takes the lowest free slot (zero result when full); a tick first charges the current
// task, if any, then sweeps all slots for the running task of least virtual time and sweeps again
// to subtract that minimum from every running slot; without a winner, the second sweep is skipped.
// One item at a time; the next one is taken only after the result is loaded; reset clears flags at once.
`include "virtual_time_task_scheduler_assert.svh"

module virtual_time_task_scheduler import vtts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // weight [15:0], slot [19:16], zero [23:20]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // kind [1:0]
  input  logic [KIND_W-1:0]    s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // chosen_slot [3:0], ok [4], task_id [36:5], zero [39:37]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  cmd_t cmd;
  sts_t sts;

  logic            in_take;
  logic            res_free;
  logic            res_fail;
  logic [ID_W-1:0] res_id;

  vtts_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  vtts_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign res_free = !m_axis_tvalid_o || m_axis_tready_i;
  assign res_fail = m_axis_tvalid_o && !m_axis_tdata_o[SLOT_W];
  assign res_id   = m_axis_tdata_o[SLOT_W+ID_W:SLOT_W+1];

  `VTTS_ASSERT_NXT(a_busy_after_accept, in_take, !s_axis_tready_o, "input taken while busy")
  `VTTS_ASSERT_NOW(a_load_when_free, cmd.out_load, res_free, "result overwritten")
  `VTTS_ASSERT_NOW(a_fail_has_zero_id, res_fail, res_id == '0, "failed result has an id")
  `VTTS_ASSERT_NXT(a_found_sets_current, cmd.scan_end && sts.found, sts.has_cur, "no current")

endmodule
